// ===== src/motion_settle_detector_assert.svh =====
// Assertion macros for the motion settle detector RTL.
`ifndef MOTION_SETTLE_DETECTOR_ASSERT_SVH
`define MOTION_SETTLE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion settle detector: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion settle detector: next-cycle check failed");

`endif

// ===== src/msd_pkg.sv =====
// Types and constants shared by the motion settle detector modules.
`default_nettype none

package msd_pkg;

    localparam int COORD_W   = 32;
    localparam int TOL_W     = 31;
    localparam int WIN_W     = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = CFG_IDX_W'(1);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t rot_x;
        coord_t rot_y;
        coord_t rot_z;
    } sample_t;

    typedef struct packed {
        logic position_settled;
        logic rotation_settled;
        logic both_settled;
    } result_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/motion_settle_detector.sv =====
// Top level of the motion settle detector: history ring of cells and walk sequencer.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    in_data   (msd_pkg::sample_t)
//   out      source     out_valid / out_ready  out_data  (msd_pkg::result_t)
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each sample is shifted into the ring, then the whole ring rotates once past cell 0
// (where the check unit reads), then the check pipeline drains and the output register
// is loaded.
// A new sample is taken only in the idle state, after the ring rotation for the last one.
// Reset clears the step count, the sequencer and the output register; the ring content
// is not cleared, and the warm-up rule keeps unwritten cells out of every result.
// A stalled output holds the finished result; the next sample is taken meanwhile and
// its result waits in the finish state until the output register frees up.
// cfg_ready is always high; write the registers only while the block is idle.
`default_nettype none

module motion_settle_detector
#(
    parameter int HISTORY_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  msd_pkg::sample_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output msd_pkg::result_t              out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msd_pkg::CFG_DAT_W-1:0] cfg_data
);
    import msd_pkg::*;

    `include "motion_settle_detector_assert.svh"

    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   step_count_reg;
    logic [CNT_W-1:0]   step_count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_data_reg;
    result_t            out_data_next;
    sample_t            cur_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [WIN_W-1:0]   window_length_reg;

    logic               in_xfer;
    logic               out_free;
    logic [CNT_W-1:0]   win_eff;
    logic               in_window;
    logic               warm;
    logic               pos_ok;
    logic               rot_ok;
    cell_ctrl_t         cell_ctrl;
    sample_t            cell_q [HISTORY_DEPTH];

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = ~out_valid_reg | out_ready;

    // Clamp the window to the ring depth.
    always_comb
    begin
        if (CMP_W'(window_length_reg) > CMP_W'(HISTORY_DEPTH))
        begin
            win_eff = DEPTH_CNT;
        end
        else
        begin
            win_eff = CNT_W'(window_length_reg);
        end
    end

    assign in_window = (state_reg == S_WALK) && (CNT_W'(cnt_reg) < win_eff);
    assign warm      = (win_eff != '0) && (step_count_reg >= win_eff);

    // Shift the new sample in on a transfer, rotate the ring during the walk.
    assign cell_ctrl.shift  = in_xfer;
    assign cell_ctrl.rotate = (state_reg == S_WALK);

    for (genvar k = 0; k < HISTORY_DEPTH; k++)
    begin : g_cell
        sample_t prev_q;
        sample_t next_q;

        if (k == 0)
        begin : g_head
            assign prev_q = in_data;
        end
        else
        begin : g_body
            assign prev_q = cell_q[k-1];
        end

        if (k == HISTORY_DEPTH - 1)
        begin : g_wrap
            assign next_q = cell_q[0];
        end
        else
        begin : g_link
            assign next_q = cell_q[k+1];
        end

        msd_cell u_cell
        (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .from_prev (prev_q),
            .from_next (next_q),
            .entry     (cell_q[k])
        );
    end

    // Check unit sits on cell 0: during walk cycle t it sees history entry t.
    msd_near u_near
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (in_xfer),
        .en        (in_window),
        .cur       (cur_reg),
        .hist      (cell_q[0]),
        .tolerance (tolerance_reg),
        .pos_ok    (pos_ok),
        .rot_ok    (rot_ok)
    );

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cur_reg <= in_data;
        end
    end

    // Configuration registers; unknown indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg     <= TOL_RESET;
            window_length_reg <= WIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOLERANCE: tolerance_reg     <= cfg_data[TOL_W-1:0];
                CFG_WINDOW:    window_length_reg <= cfg_data[WIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_count_next = step_count_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next   = '0;
                    state_next = S_WALK;
                    if (step_count_reg != DEPTH_CNT)
                    begin
                        step_count_next = step_count_reg + CNT_W'(1);
                    end
                end
            end
            S_WALK:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Hold the result until the output register is free.
                if (out_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.position_settled = warm & pos_ok;
                    out_data_next.rotation_settled = warm & rot_ok;
                    out_data_next.both_settled     = warm & pos_ok & rot_ok;
                    state_next                     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            step_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            step_count_reg <= step_count_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MSD_ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, in_xfer,
                     (state_reg == S_WALK) && (cnt_reg == '0))
    `MSD_ASSERT_NEXT(a_walk_ends_in_drain, clk, rst_n,
                     (state_reg == S_WALK) && (cnt_reg == LAST_IDX), state_reg == S_DRAIN)
    `MSD_ASSERT_NOW(a_step_count_bounded, clk, rst_n, 1'b1, step_count_reg <= DEPTH_CNT)
    `MSD_ASSERT_NOW(a_both_is_and, clk, rst_n, out_valid_reg,
                    out_data_reg.both_settled ==
                    (out_data_reg.position_settled & out_data_reg.rotation_settled))

endmodule

`default_nettype wire

// ===== src/msd_cell.sv =====
// One history cell: holds one sample, loads from either neighbor.
`default_nettype none

module msd_cell
(
    input  logic                clk,
    input  msd_pkg::cell_ctrl_t ctrl,
    input  msd_pkg::sample_t    from_prev,
    input  msd_pkg::sample_t    from_next,
    output msd_pkg::sample_t    entry
);
    import msd_pkg::*;

    sample_t entry_reg;
    sample_t entry_next;

    // Shift moves toward older entries; rotate walks the ring toward cell 0.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = from_prev;
        end
        else if (ctrl.rotate)
        begin
            entry_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== src/msd_near.sv =====
// Tolerance check unit: registered differences, then per-axis test and accumulate.
`default_nettype none

module msd_near
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      en,
    input  msd_pkg::sample_t          cur,
    input  msd_pkg::sample_t          hist,
    input  logic [msd_pkg::TOL_W-1:0] tolerance,
    output logic                      pos_ok,
    output logic                      rot_ok
);
    import msd_pkg::*;

    localparam int AXES = 6;

    typedef logic signed [COORD_W:0] diff_t;

    diff_t diff_reg  [AXES];
    diff_t diff_next [AXES];
    logic  en_reg;
    logic  pos_ok_reg;
    logic  pos_ok_next;
    logic  rot_ok_reg;
    logic  rot_ok_next;
    logic  [AXES-1:0] axis_ok;

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        diff_t ae;
        diff_t be;
        ae = signed'({a[COORD_W-1], a});
        be = signed'({b[COORD_W-1], b});
        return ae - be;
    endfunction

    // |d| <= tol: nonnegative d compares directly, negative d checks d + tol >= 0.
    function automatic logic within_tol(diff_t d, logic [TOL_W-1:0] tol);
        logic signed [COORD_W+1:0] d_ext;
        logic signed [COORD_W+1:0] t_ext;
        logic signed [COORD_W+1:0] sum;
        d_ext = signed'({d[COORD_W], d});
        t_ext = signed'({{(COORD_W + 2 - TOL_W){1'b0}}, tol});
        sum   = d_ext + t_ext;
        if (d[COORD_W])
        begin
            return !sum[COORD_W+1];
        end
        return (d_ext <= t_ext);
    endfunction

    always_comb
    begin
        diff_next[0] = sub_ext(cur.pos_x, hist.pos_x);
        diff_next[1] = sub_ext(cur.pos_y, hist.pos_y);
        diff_next[2] = sub_ext(cur.pos_z, hist.pos_z);
        diff_next[3] = sub_ext(cur.rot_x, hist.rot_x);
        diff_next[4] = sub_ext(cur.rot_y, hist.rot_y);
        diff_next[5] = sub_ext(cur.rot_z, hist.rot_z);
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            axis_ok[a] = within_tol(diff_reg[a], tolerance);
        end
    end

    always_comb
    begin
        pos_ok_next = pos_ok_reg;
        rot_ok_next = rot_ok_reg;
        if (clear)
        begin
            pos_ok_next = 1'b1;
            rot_ok_next = 1'b1;
        end
        else if (en_reg)
        begin
            pos_ok_next = pos_ok_reg & (&axis_ok[2:0]);
            rot_ok_next = rot_ok_reg & (&axis_ok[5:3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b0;
            pos_ok_reg <= 1'b1;
            rot_ok_reg <= 1'b1;
        end
        else
        begin
            en_reg     <= en & ~clear;
            pos_ok_reg <= pos_ok_next;
            rot_ok_reg <= rot_ok_next;
        end
    end

    assign pos_ok = pos_ok_reg;
    assign rot_ok = rot_ok_reg;

endmodule

`default_nettype wire
